// ===== hdl/gne_pkg.sv =====
package gne_pkg;

  localparam int unsigned MAX_COLS = 128;
  localparam int unsigned MAX_ROWS = 128;
  localparam int unsigned COORD_W  = 7;
  localparam int unsigned DIM_W    = 8;
  localparam int unsigned EST_W    = 8;
  localparam int unsigned NB_N     = 8;
  localparam int unsigned ROW_AW   = $clog2(MAX_ROWS);

  // Coordinates reach 127 at most, so no side ever exceeds 128 cells
  localparam int unsigned COORD_CAP = 1 << COORD_W;

  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(COORD_CAP);
  localparam logic [DIM_W-1:0] COL_LIM =
    DIM_W'((MAX_COLS < COORD_CAP) ? MAX_COLS : COORD_CAP);
  localparam logic [DIM_W-1:0] ROW_LIM =
    DIM_W'((MAX_ROWS < COORD_CAP) ? MAX_ROWS : COORD_CAP);

  // Register indexes on the configuration port
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Which row around the node a read targets
  localparam logic [1:0] ROW_ABOVE = 2'd0;
  localparam logic [1:0] ROW_NODE  = 2'd1;
  localparam logic [1:0] ROW_BELOW = 2'd2;

  typedef struct packed {
    logic       clr;     // clear one map row
    logic       wr;      // store one map cell from the input ports
    logic       load;    // latch node and goal
    logic       rd;      // read one map row
    logic [1:0] rd_row;  // row selector for the read
    logic [2:0] cap;     // one-hot: window row taking the read data
    logic       build;   // form the neighbour mask
    logic       emit;    // drive one result
  } gne_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic emit_last;
  } gne_sts_t;

endpackage

// ===== hdl/gne_ctrl.sv =====
module gne_ctrl
  import gne_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_action,
  input  gne_sts_t sts,
  output gne_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD0   = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_RD2   = 7'b0010000,
    S_CAP   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } gne_state_t;

  gne_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_row = ROW_ABOVE;
    busy       = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_action) begin
            cmd.load  = 1'b1;
            state_nxt = S_RD0;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_RD0: begin
        cmd.rd     = 1'b1;
        cmd.rd_row = ROW_ABOVE;
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        cmd.rd     = 1'b1;
        cmd.rd_row = ROW_NODE;
        cmd.cap    = 3'b001;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        cmd.rd     = 1'b1;
        cmd.rd_row = ROW_BELOW;
        cmd.cap    = 3'b010;
        state_nxt  = S_CAP;
      end
      S_CAP: begin
        cmd.cap   = 3'b100;
        state_nxt = S_EMIT;
        cmd.build = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== hdl/gne_dp.sv =====
module gne_dp
  import gne_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  gne_cmd_t           cmd,
  output gne_sts_t           sts,
  input  logic [COORD_W-1:0] in_node_x,
  input  logic [COORD_W-1:0] in_node_y,
  input  logic               in_blocked,
  input  logic [COORD_W-1:0] in_goal_x,
  input  logic [COORD_W-1:0] in_goal_y,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DIM_W-1:0]   cfg_wdata,
  output logic               out_strobe,
  output logic               out_valid_res,
  output logic [COORD_W-1:0] out_nb_x,
  output logic [COORD_W-1:0] out_nb_y,
  output logic [EST_W-1:0]   out_estimate,
  output logic               out_last
);

  logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_q_r;
  logic [ROW_AW-1:0]   clr_cnt_r;
  logic [ROW_AW-1:0]   rd_addr;

  logic [DIM_W-1:0]   grid_w_r, grid_h_r;
  logic [COORD_W-1:0] node_x_r, node_y_r, goal_x_r, goal_y_r;
  logic [2:0]         win_r [3];
  logic [NB_N-1:0]    mask_r;

  logic [DIM_W-1:0]   w_use, h_use;
  logic [COORD_W-1:0] x_m1, x_p1;
  logic [2:0]         fr3 [3];
  logic [NB_N-1:0]    mask_new;
  logic [NB_N-1:0]    first_oh;
  logic [2:0]         first_idx;
  logic [COORD_W-1:0] nb_x, nb_y;
  logic [EST_W-1:0]   dist_x, dist_y;

  logic               strobe_r, valid_r, last_r;
  logic [COORD_W-1:0] nb_x_r, nb_y_r;
  logic [EST_W-1:0]   est_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= DIM_CAP;
      grid_h_r <= DIM_CAP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_use = (grid_w_r > COL_LIM) ? COL_LIM : grid_w_r;
  assign h_use = (grid_h_r > ROW_LIM) ? ROW_LIM : grid_h_r;

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt_r == ROW_AW'(MAX_ROWS - 1));

  always_comb begin
    case (cmd.rd_row)
      ROW_ABOVE: rd_addr = node_y_r - 1'b1;
      ROW_NODE:  rd_addr = node_y_r;
      ROW_BELOW: rd_addr = node_y_r + 1'b1;
      default:   rd_addr = node_y_r;
    endcase
  end

  // Map memory: one row per word, bit-wise write
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      map_mem[clr_cnt_r] <= '0;
    end else if (cmd.wr) begin
      map_mem[in_node_y][in_node_x] <= in_blocked;
    end
    if (cmd.rd) begin
      rd_q_r <= map_mem[rd_addr];
    end
  end

  assign x_m1 = node_x_r - 1'b1;
  assign x_p1 = node_x_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_x_r <= in_node_x;
      node_y_r <= in_node_y;
      goal_x_r <= in_goal_x;
      goal_y_r <= in_goal_y;
    end
    for (int r = 0; r < 3; r++) begin
      if (cmd.cap[r]) begin
        win_r[r] <= {rd_q_r[x_p1], rd_q_r[node_x_r], rd_q_r[x_m1]};
      end
    end
  end

  // Free test of the 3x3 window; the last row arrives this cycle
  always_comb begin
    logic [DIM_W-1:0] ry, cx;
    logic [2:0]       bits;
    for (int r = 0; r < 3; r++) begin
      ry   = {1'b0, node_y_r} + DIM_W'(r) - 1'b1;
      bits = (r == 2) ? {rd_q_r[x_p1], rd_q_r[node_x_r], rd_q_r[x_m1]} : win_r[r];
      for (int c = 0; c < 3; c++) begin
        cx        = {1'b0, node_x_r} + DIM_W'(c) - 1'b1;
        fr3[r][c] = (cx < w_use) && (ry < h_use) && !bits[c];
      end
    end
    mask_new[0] = fr3[1][2];
    mask_new[1] = fr3[1][0];
    mask_new[2] = fr3[2][1];
    mask_new[3] = fr3[0][1];
    mask_new[4] = fr3[1][2] & fr3[2][1] & fr3[2][2];
    mask_new[5] = fr3[1][0] & fr3[0][1] & fr3[0][0];
    mask_new[6] = fr3[1][0] & fr3[2][1] & fr3[2][0];
    mask_new[7] = fr3[1][2] & fr3[0][1] & fr3[0][2];
  end

  // Pick the next neighbour in emission order
  always_comb begin
    first_oh  = '0;
    first_idx = '0;
    for (int i = NB_N - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        first_oh  = NB_N'(1) << i;
        first_idx = 3'(i);
      end
    end
  end

  always_comb begin
    case (first_idx)
      3'd0:    begin nb_x = x_p1;     nb_y = node_y_r;        end
      3'd1:    begin nb_x = x_m1;     nb_y = node_y_r;        end
      3'd2:    begin nb_x = node_x_r; nb_y = node_y_r + 1'b1; end
      3'd3:    begin nb_x = node_x_r; nb_y = node_y_r - 1'b1; end
      3'd4:    begin nb_x = x_p1;     nb_y = node_y_r + 1'b1; end
      3'd5:    begin nb_x = x_m1;     nb_y = node_y_r - 1'b1; end
      3'd6:    begin nb_x = x_m1;     nb_y = node_y_r + 1'b1; end
      default: begin nb_x = x_p1;     nb_y = node_y_r - 1'b1; end
    endcase
  end

  assign dist_x = (nb_x >= goal_x_r) ? EST_W'(nb_x - goal_x_r) : EST_W'(goal_x_r - nb_x);
  assign dist_y = (nb_y >= goal_y_r) ? EST_W'(nb_y - goal_y_r) : EST_W'(goal_y_r - nb_y);

  assign sts.emit_last = ((mask_r & ~first_oh) == '0);

  always_ff @(posedge clk) begin
    if (cmd.build) begin
      mask_r <= mask_new;
    end else if (cmd.emit) begin
      mask_r <= mask_r & ~first_oh;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_r <= sts.emit_last;
      if (mask_r == '0) begin
        valid_r <= 1'b0;
        nb_x_r  <= '0;
        nb_y_r  <= '0;
        est_r   <= '0;
      end else begin
        valid_r <= 1'b1;
        nb_x_r  <= nb_x;
        nb_y_r  <= nb_y;
        est_r   <= dist_x + dist_y;
      end
    end
  end

  assign out_strobe    = strobe_r;
  assign out_valid_res = valid_r;
  assign out_nb_x      = nb_x_r;
  assign out_nb_y      = nb_y_r;
  assign out_estimate  = est_r;
  assign out_last      = last_r;

endmodule

// ===== hdl/grid_neighbor_expander.sv =====
// Channel   Ports                                   Transaction
// --------  --------------------------------------  ---------------------------------
// input     start, busy, in_action .. in_goal_y     start & !busy at a rising edge
// result    out_strobe, out_valid_res .. out_last   one cycle with out_strobe high
// config    cfg_we, cfg_index, cfg_wdata            cfg_we at a rising edge
//
// A map write leaves busy low. An expansion holds busy high until its last result is
// registered: three reads of the single-port row memory (rows above, at and below the
// node), a step to form the neighbour mask, then one result per cycle, 1 to 8 results
// in all; the block takes no new item before it is through with the last one.
// After reset the map is swept clear one row a cycle, all 128 rows, with busy high.
module grid_neighbor_expander
  import gne_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [COORD_W-1:0] in_node_x,
  input  logic [COORD_W-1:0] in_node_y,
  input  logic               in_blocked,
  input  logic [COORD_W-1:0] in_goal_x,
  input  logic [COORD_W-1:0] in_goal_y,
  output logic               out_strobe,
  output logic               out_valid_res,
  output logic [COORD_W-1:0] out_nb_x,
  output logic [COORD_W-1:0] out_nb_y,
  output logic [EST_W-1:0]   out_estimate,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DIM_W-1:0]   cfg_wdata
);

  gne_cmd_t cmd;
  gne_sts_t sts;

  // Sequence the clear sweep, the row reads and the emission
  gne_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the map, the grid bounds and the neighbour window; drive results
  gne_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_node_x     (in_node_x),
    .in_node_y     (in_node_y),
    .in_blocked    (in_blocked),
    .in_goal_x     (in_goal_x),
    .in_goal_y     (in_goal_y),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_strobe    (out_strobe),
    .out_valid_res (out_valid_res),
    .out_nb_x      (out_nb_x),
    .out_nb_y      (out_nb_y),
    .out_estimate  (out_estimate),
    .out_last      (out_last)
  );

endmodule

// ===== tb/grid_neighbor_expander_tb.sv =====
module grid_neighbor_expander_tb
  import gne_pkg::*;
();

  // Item kinds on in_action
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_EXPAND = 1'b1;

  // Settling margin after the last result, above the longest expansion
  localparam int SETTLE_CYCLES  = 16;
  // Longest quiet stretch in a correct run is the clearing sweep after reset
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;
  localparam int COORD_SPAN     = 1 << COORD_W;

  // Neighbour offsets in emission order: right, left, down, up,
  // down-right, up-left, down-left, up-right
  localparam int STEP_X [8] = '{1, -1, 0, 0, 1, -1, -1, 1};
  localparam int STEP_Y [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

  typedef struct packed {
    logic               valid_res;
    logic [COORD_W-1:0] nb_x;
    logic [COORD_W-1:0] nb_y;
    logic [EST_W-1:0]   estimate;
    logic               last;
  } nbr_t;

  // Tracks the obstacle map and grid size, predicts the neighbours of every
  // accepted expansion and checks them against what the block emits.
  class expansion_tracker;
    bit               blocked_cell [MAX_ROWS][MAX_COLS];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    nbr_t             expected_nbrs [$];
    int               failures;
    int               writes;
    int               expansions;
    int               results;

    function new();
      width_reg  = DIM_CAP;
      height_reg = DIM_CAP;
      failures   = 0;
      writes     = 0;
      expansions = 0;
      results    = 0;
    endfunction

    function void set_reg(logic idx, logic [DIM_W-1:0] value);
      if (idx == CFG_GRID_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    // Cells beyond the columns or rows in use count as obstacles
    function bit cell_free(int x, int y);
      int w;
      int h;
      w = int'(width_reg);
      if (w > int'(MAX_COLS)) w = int'(MAX_COLS);
      if (w > COORD_SPAN) w = COORD_SPAN;
      h = int'(height_reg);
      if (h > int'(MAX_ROWS)) h = int'(MAX_ROWS);
      if (h > COORD_SPAN) h = COORD_SPAN;
      if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
      return !blocked_cell[y][x];
    endfunction

    function void expand_node(int x, int y, int gx, int gy);
      bit   ok [8];
      int   final_k;
      int   ax;
      int   ay;
      nbr_t e;
      for (int k = 0; k < 4; k++) ok[k] = cell_free(x + STEP_X[k], y + STEP_Y[k]);
      // No corner cutting: a diagonal needs both orthogonal cells beside it free
      ok[4] = ok[0] && ok[2] && cell_free(x + STEP_X[4], y + STEP_Y[4]);
      ok[5] = ok[1] && ok[3] && cell_free(x + STEP_X[5], y + STEP_Y[5]);
      ok[6] = ok[1] && ok[2] && cell_free(x + STEP_X[6], y + STEP_Y[6]);
      ok[7] = ok[0] && ok[3] && cell_free(x + STEP_X[7], y + STEP_Y[7]);
      final_k = -1;
      for (int k = 0; k < 8; k++) if (ok[k]) final_k = k;
      expansions++;
      if (final_k < 0) begin
        e.valid_res = 1'b0;
        e.nb_x      = '0;
        e.nb_y      = '0;
        e.estimate  = '0;
        e.last      = 1'b1;
        expected_nbrs.push_back(e);
        return;
      end
      for (int k = 0; k < 8; k++) begin
        if (ok[k]) begin
          ax          = x + STEP_X[k];
          ay          = y + STEP_Y[k];
          e.valid_res = 1'b1;
          e.nb_x      = COORD_W'(ax);
          e.nb_y      = COORD_W'(ay);
          e.estimate  = EST_W'(((ax > gx) ? ax - gx : gx - ax) +
                               ((ay > gy) ? ay - gy : gy - ay));
          e.last      = (k == final_k);
          expected_nbrs.push_back(e);
        end
      end
    endfunction

    function void note_item(logic action, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic blk, logic [COORD_W-1:0] gx, logic [COORD_W-1:0] gy);
      if (action == ACT_WRITE) begin
        blocked_cell[y][x] = blk;
        writes++;
      end else begin
        expand_node(int'(x), int'(y), int'(gx), int'(gy));
      end
    endfunction

    function void check_nbr(nbr_t got);
      nbr_t want;
      results++;
      if (expected_nbrs.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: valid=%0d x=%0d y=%0d est=%0d last=%0d",
                   got.valid_res, got.nb_x, got.nb_y, got.estimate, got.last);
        return;
      end
      want = expected_nbrs.pop_front();
      if (got.valid_res !== want.valid_res || got.nb_x !== want.nb_x ||
          got.nb_y !== want.nb_y || got.estimate !== want.estimate ||
          got.last !== want.last) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch: expected valid=%0d x=%0d y=%0d est=%0d last=%0d",
                   want.valid_res, want.nb_x, want.nb_y, want.estimate, want.last);
          $display("          got      valid=%0d x=%0d y=%0d est=%0d last=%0d",
                   got.valid_res, got.nb_x, got.nb_y, got.estimate, got.last);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_action;
  logic [COORD_W-1:0] in_node_x;
  logic [COORD_W-1:0] in_node_y;
  logic               in_blocked;
  logic [COORD_W-1:0] in_goal_x;
  logic [COORD_W-1:0] in_goal_y;
  logic               out_strobe;
  logic               out_valid_res;
  logic [COORD_W-1:0] out_nb_x;
  logic [COORD_W-1:0] out_nb_y;
  logic [EST_W-1:0]   out_estimate;
  logic               out_last;
  logic               cfg_we;
  logic               cfg_index;
  logic [DIM_W-1:0]   cfg_wdata;

  expansion_tracker book;
  int               idle_cycles;
  int               settings_run;

  grid_neighbor_expander dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_node_x    (in_node_x),
    .in_node_y    (in_node_y),
    .in_blocked   (in_blocked),
    .in_goal_x    (in_goal_x),
    .in_goal_y    (in_goal_y),
    .out_strobe   (out_strobe),
    .out_valid_res(out_valid_res),
    .out_nb_x     (out_nb_x),
    .out_nb_y     (out_nb_y),
    .out_estimate (out_estimate),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Check every result in the cycle it is strobed; the receiver cannot stall,
  // so each strobe is one transaction.
  always @(posedge clk) begin : result_monitor
    nbr_t got;
    if (rst_n && out_strobe) begin
      got.valid_res = out_valid_res;
      got.nb_x      = out_nb_x;
      got.nb_y      = out_nb_y;
      got.estimate  = out_estimate;
      got.last      = out_last;
      book.check_nbr(got);
    end
  end

  // Watchdog: count cycles in which no transaction of any kind takes place
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("grid_neighbor_expander_tb: FAIL");
        $finish;
      end
    end
  end

  // Present one item from a falling edge and hold it until the block takes it.
  // Leave start high afterwards so back-to-back items need no gap.
  task automatic send_item(logic action, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic blk, logic [COORD_W-1:0] gx, logic [COORD_W-1:0] gy);
    start      = 1'b1;
    in_action  = action;
    in_node_x  = x;
    in_node_y  = y;
    in_blocked = blk;
    in_goal_x  = gx;
    in_goal_y  = gy;
    do @(posedge clk); while (busy);
    book.note_item(action, x, y, blk, gx, gy);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off the sender until every expected neighbour has come out, then let
  // the block finish any trailing work before going on.
  task automatic drain();
    start = 1'b0;
    while (book.expected_nbrs.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    book.set_reg(idx, value);
  endtask

  // Mostly pick a cell close to the current cluster centre so that obstacles
  // pile up around the nodes being expanded; now and then pick any cell.
  function automatic logic [COORD_W-1:0] pick_coord(int centre);
    int v;
    if ($urandom_range(0, 99) < 75) begin
      v = centre + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > COORD_SPAN - 1) v = COORD_SPAN - 1;
    end else begin
      v = int'($urandom_range(0, COORD_SPAN - 1));
    end
    return COORD_W'(v);
  endfunction

  // One grid setting: drain, reprogram, then a burst of random writes and
  // expansions with one drain partway; each cycle the sender could present an item
  // it stays idle with the given chance.
  task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int idle_pct,
                           int count);
    int   span_x;
    int   span_y;
    int   cx;
    int   cy;
    int   pause_at;
    logic act;
    logic blk;
    drain();
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    // Centres may sit one cell past the edge so the boundary gets exercised
    span_x   = (int'(w) > COORD_SPAN - 1) ? COORD_SPAN - 1 : int'(w);
    span_y   = (int'(h) > COORD_SPAN - 1) ? COORD_SPAN - 1 : int'(h);
    cx       = 0;
    cy       = 0;
    pause_at = int'($urandom_range(count / 4, 3 * count / 4));
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        cx = int'($urandom_range(0, span_x));
        cy = int'($urandom_range(0, span_y));
      end
      act = ($urandom_range(0, 99) < 55) ? ACT_EXPAND : ACT_WRITE;
      blk = ($urandom_range(0, 99) < 40);
      while ($urandom_range(0, 99) < idle_pct) pause_sender(1);
      if (i == pause_at) drain();
      send_item(act, pick_coord(cx), pick_coord(cy), blk,
                COORD_W'($urandom_range(0, COORD_SPAN - 1)),
                COORD_W'($urandom_range(0, COORD_SPAN - 1)));
    end
    settings_run++;
  endtask

  initial begin
    book         = new();
    idle_cycles  = 0;
    settings_run = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_WRITE;
    in_node_x    = '0;
    in_node_y    = '0;
    in_blocked   = 1'b0;
    in_goal_x    = '0;
    in_goal_y    = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_GRID_WIDTH;
    cfg_wdata    = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait out the map-clearing sweep before touching the registers
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);
    write_reg(CFG_GRID_WIDTH, DIM_CAP);
    write_reg(CFG_GRID_HEIGHT, DIM_CAP);

    // Directed: grid corners and the far edge, largest estimate, a node with
    // no free neighbour, a blocked node, corner cutting, and freeing a cell.
    send_item(ACT_EXPAND, 7'd0, 7'd0, 1'b0, 7'd127, 7'd127);
    send_item(ACT_EXPAND, 7'd126, 7'd126, 1'b0, 7'd0, 7'd0);
    send_item(ACT_EXPAND, 7'd127, 7'd127, 1'b1, 7'd127, 7'd0);
    send_item(ACT_EXPAND, 7'd64, 7'd0, 1'b0, 7'd64, 7'd127);
    send_item(ACT_WRITE, 7'd1, 7'd0, 1'b1, 7'd0, 7'd0);
    send_item(ACT_WRITE, 7'd0, 7'd1, 1'b1, 7'd0, 7'd0);
    send_item(ACT_EXPAND, 7'd0, 7'd0, 1'b0, 7'd5, 7'd5);
    send_item(ACT_EXPAND, 7'd1, 7'd0, 1'b0, 7'd5, 7'd5);
    send_item(ACT_WRITE, 7'd41, 7'd40, 1'b1, 7'd127, 7'd127);
    send_item(ACT_EXPAND, 7'd40, 7'd40, 1'b0, 7'd0, 7'd127);
    send_item(ACT_WRITE, 7'd40, 7'd41, 1'b1, 7'd0, 7'd0);
    send_item(ACT_EXPAND, 7'd40, 7'd40, 1'b0, 7'd85, 7'd42);
    send_item(ACT_WRITE, 7'd1, 7'd0, 1'b0, 7'd0, 7'd0);
    send_item(ACT_EXPAND, 7'd0, 7'd0, 1'b0, 7'd0, 7'd0);
    send_item(ACT_WRITE, 7'd127, 7'd127, 1'b1, 7'd0, 7'd0);
    send_item(ACT_EXPAND, 7'd126, 7'd126, 1'b0, 7'd0, 7'd0);

    // Random part across grid sizes: full, small, single column or row,
    // saturating values, zero (everything blocked) and one short of full.
    run_phase(8'd128, 8'd128, 0, 54);
    run_phase(8'd16, 8'd9, 55, 54);
    run_phase(8'd1, 8'd128, 0, 54);
    run_phase(8'd255, 8'd200, 10, 54);
    run_phase(8'd5, 8'd1, 55, 54);
    run_phase(8'd0, 8'd128, 10, 54);
    run_phase(8'd128, 8'd2, 0, 54);
    run_phase(8'd127, 8'd127, 55, 54);
    drain();

    // Anything still queued now was never produced
    if (book.expected_nbrs.size() > 0) begin
      $display("%0d expected results never arrived", book.expected_nbrs.size());
      book.failures += book.expected_nbrs.size();
    end

    $display("covered %0d map writes and %0d expansions, %0d neighbour results checked",
             book.writes, book.expansions, book.results);
    $display("over %0d grid settings from 0 to 255 per side, sender idling up to 55%%",
             settings_run);
    if (book.failures == 0) begin
      $display("grid_neighbor_expander_tb: PASS");
    end else begin
      $display("grid_neighbor_expander_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gne_pkg.sv
hdl/gne_ctrl.sv
hdl/gne_dp.sv
hdl/grid_neighbor_expander.sv
tb/grid_neighbor_expander_tb.sv
